@@ design/wbps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

	localparam int DATA_W     = 8;
	localparam int LEN_W      = 5;
	localparam int SEEN_W     = 32;
	localparam int OUT_ADDR_W = 32;
	localparam int BASE_W     = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int MASK_W     = 16;
	localparam int SIG_CAP    = 16;

	localparam logic [LEN_W-1:0] SIG_LEN_RESET = LEN_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIG_LOW     = 3'd0,
		REG_SIG_HIGH    = 3'd1,
		REG_WILD_MASK   = 3'd2,
		REG_SIG_LENGTH  = 3'd3,
		REG_FIND_ALL    = 3'd4,
		REG_REGION_BASE = 3'd5
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ design/wbps_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface wbps_byte_if import wbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              region_end;

	modport source (output valid, output data_byte, output region_end, input ready);
	modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_result_if import wbps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [OUT_ADDR_W-1:0] match_address;
	logic                  is_final;

	modport source (output valid, output found, output match_address, output is_final,
		input ready);
	modport sink (input valid, input found, input match_address, input is_final,
		output ready);
endinterface

`default_nettype wire

@@ design/wbps_match.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wbps_match import wbps_pkg::*; #(
	parameter int MAX_SIG_LEN = 16
) (
	input  wire logic [MAX_SIG_LEN-1:0][DATA_W-1:0] window,
	input  wire logic [2*CFG_DATA_W-1:0]            sig_bytes,
	input  wire logic [MASK_W-1:0]                  wild_mask,
	input  wire logic [LEN_W-1:0]                   len,
	output logic                                    hit
);

	localparam int IW = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;

	logic [LEN_W-1:0] idx;

	// signature byte k lines up with window entry len-1-k, all positions in parallel
	always_comb begin
		hit = 1'b1;
		idx = '0;
		for (int k = 0; k < MAX_SIG_LEN; k++) begin
			if (LEN_W'(k) < len) begin
				idx = len - LEN_W'(k) - LEN_W'(1);
				if (!wild_mask[k] && window[idx[IW-1:0]] != sig_bytes[DATA_W*k +: DATA_W]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ design/wildcard_byte_pattern_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none

// a byte accepted is registered in the input stage (valid_s1), and its result then in the output register (res_valid_q)
// throughput: one byte per cycle; a byte with a result waits while the output register is held
// bytes that give no result retire without waiting on the output side
// reset (arst_n low, async): config returns to defaults with sig_length 4, scan state
// and both valid flags clear; the scan state also clears after each region_end byte
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
	parameter int MAX_SIG_LEN = 16,
	parameter int ADDR_WIDTH  = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	wbps_byte_if.sink                  stream,
	wbps_result_if.source              result
);

	// configuration
	logic [CFG_DATA_W-1:0] sig_low_q;
	logic [CFG_DATA_W-1:0] sig_high_q;
	logic [MASK_W-1:0]     wmask_q;
	logic [LEN_W-1:0]      sig_len_q;
	logic                  find_all_q;
	logic [BASE_W-1:0]     region_base_q;

	// scan state
	logic [MAX_SIG_LEN-1:0][DATA_W-1:0] window_q;
	logic [SEEN_W-1:0]                  seen_q;
	logic                               first_q;
	logic [LEN_W-1:0]                   skip_q;

	// input stage
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              end_s1;

	// result register
	logic                  res_valid_q;
	logic                  res_found_q;
	logic [OUT_ADDR_W-1:0] res_addr_q;
	logic                  res_final_q;

	logic [MAX_SIG_LEN-1:0][DATA_W-1:0] window_next;
	logic [SEEN_W-1:0]                  seen_next;
	logic [LEN_W-1:0]                   len_c;
	logic                               hit;
	logic                               match;
	logic                               report;
	logic                               emit;
	logic                               advance;
	logic [SEEN_W-1:0]                  offset;
	logic [ADDR_WIDTH-1:0]              addr_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_low_q     <= '0;
			sig_high_q    <= '0;
			wmask_q       <= '0;
			sig_len_q     <= SIG_LEN_RESET;
			find_all_q    <= 1'b0;
			region_base_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SIG_LOW:     sig_low_q     <= cfg_data;
				REG_SIG_HIGH:    sig_high_q    <= cfg_data;
				REG_WILD_MASK:   wmask_q       <= cfg_data[MASK_W-1:0];
				REG_SIG_LENGTH:  sig_len_q     <= cfg_data[LEN_W-1:0];
				REG_FIND_ALL:    find_all_q    <= cfg_data[0];
				REG_REGION_BASE: region_base_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		window_next[0] = data_s1;
		for (int j = 1; j < MAX_SIG_LEN; j++) begin
			window_next[j] = window_q[j-1];
		end
	end

	assign seen_next = (seen_q == {SEEN_W{1'b1}}) ? seen_q : seen_q + SEEN_W'(1);
	assign len_c = (sig_len_q > LEN_W'(MAX_SIG_LEN)) ? LEN_W'(MAX_SIG_LEN) : sig_len_q;

	wbps_match #(
		.MAX_SIG_LEN(MAX_SIG_LEN)
	) u_match (
		.window   (window_next),
		.sig_bytes({sig_high_q, sig_low_q}),
		.wild_mask(wmask_q),
		.len      (len_c),
		.hit      (hit)
	);

	assign match  = hit && (len_c != '0) && (seen_next >= SEEN_W'(len_c));
	assign report = valid_s1 && (skip_q == '0) && match && (find_all_q || !first_q);
	assign emit   = valid_s1 && (report || end_s1);

	// a byte with nothing to emit moves on even while the output is held
	assign advance      = valid_s1 && (!emit || !res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	// address wraps at the configured address width
	assign offset    = seen_next - SEEN_W'(len_c);
	assign addr_full = ADDR_WIDTH'(region_base_q) + ADDR_WIDTH'(offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= '0;
			end_s1   <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
			data_s1  <= stream.data_byte;
			end_s1   <= stream.region_end;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			first_q  <= 1'b0;
			skip_q   <= '0;
		end else if (advance) begin
			if (end_s1) begin
				window_q <= '0;
				seen_q   <= '0;
				first_q  <= 1'b0;
				skip_q   <= '0;
			end else begin
				window_q <= window_next;
				seen_q   <= seen_next;
				if (skip_q != '0) begin
					skip_q <= skip_q - LEN_W'(1);
				end else if (report) begin
					first_q <= 1'b1;
					skip_q  <= len_c - LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_found_q <= 1'b0;
			res_addr_q  <= '0;
			res_final_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
			res_found_q <= report;
			res_addr_q  <= report ? OUT_ADDR_W'(addr_full) : '0;
			res_final_q <= end_s1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.found         = res_found_q;
	assign result.match_address = res_addr_q;
	assign result.is_final      = res_final_q;

endmodule

`default_nettype wire

@@ bench/wbps_match_checker.sv @@
`timescale 1ns / 1ps

module wbps_match_checker import wbps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wbps_byte_if                  stream,
	wbps_result_if                result,
	output int                    fail_count,
	output int                    results_pending
);

	typedef struct packed {
		logic                  found;
		logic [OUT_ADDR_W-1:0] match_address;
		logic                  is_final;
	} match_report_t;

	// scanner registers as last written
	logic [63:0]       sig_lo, sig_hi;
	logic [MASK_W-1:0] wild_mask;
	logic [LEN_W-1:0]  sig_len;
	logic              find_all;
	logic [BASE_W-1:0] base_addr;

	// per-region scan state
	logic [DATA_W-1:0] window [SIG_CAP];
	logic [SEEN_W-1:0] seen;
	logic              reported;
	logic [LEN_W-1:0]  skip_left;

	match_report_t match_reports [$];
	match_report_t rep, got;
	logic          emit;

	function automatic void advance_scanner(input logic [DATA_W-1:0] b, input logic last,
		output logic produce, output match_report_t r);
		int                    eff_len;
		logic                  hit;
		logic                  take;
		logic [OUT_ADDR_W-1:0] start_addr;
		logic [DATA_W-1:0]     sig_b;
		eff_len = (sig_len > SIG_CAP) ? SIG_CAP : int'(sig_len);
		for (int k = SIG_CAP - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = b;
		if (seen != '1)
			seen = seen + SEEN_W'(1);
		hit = 1'b0;
		if (eff_len > 0 && seen >= SEEN_W'(eff_len)) begin
			hit = 1'b1;
			for (int k = 0; k < eff_len; k++) begin
				sig_b = (k < 8) ? sig_lo[8*k +: 8] : sig_hi[8*(k-8) +: 8];
				if (!wild_mask[k] && window[eff_len-1-k] != sig_b)
					hit = 1'b0;
			end
		end
		take = 1'b0;
		start_addr = '0;
		if (skip_left != '0) begin
			skip_left = skip_left - LEN_W'(1);
		end else if (hit && (find_all || !reported)) begin
			take = 1'b1;
			reported = 1'b1;
			skip_left = LEN_W'(eff_len - 1);
			start_addr = base_addr + (seen - SEEN_W'(eff_len));
		end
		produce = take || last;
		r = '{found: take, match_address: start_addr, is_final: last};
		if (last) begin
			foreach (window[k])
				window[k] = '0;
			seen = '0;
			reported = 1'b0;
			skip_left = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_lo = '0;
			sig_hi = '0;
			wild_mask = '0;
			sig_len = SIG_LEN_RESET;
			find_all = 1'b0;
			base_addr = '0;
			foreach (window[k])
				window[k] = '0;
			seen = '0;
			reported = 1'b0;
			skip_left = '0;
			match_reports.delete();
			results_pending = 0;
			fail_count = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_SIG_LOW:     sig_lo = cfg_data;
					REG_SIG_HIGH:    sig_hi = cfg_data;
					REG_WILD_MASK:   wild_mask = cfg_data[MASK_W-1:0];
					REG_SIG_LENGTH:  sig_len = cfg_data[LEN_W-1:0];
					REG_FIND_ALL:    find_all = cfg_data[0];
					REG_REGION_BASE: base_addr = cfg_data[BASE_W-1:0];
					default: ;
				endcase
			end
			if (stream.valid && stream.ready) begin
				advance_scanner(stream.data_byte, stream.region_end, emit, rep);
				if (emit)
					match_reports = {match_reports, rep};
			end
			if (result.valid && result.ready) begin
				got = '{found: result.found, match_address: result.match_address,
					is_final: result.is_final};
				if (match_reports.size() == 0) begin
					$error("unexpected result transaction: found %0d, %s %h, is_final %0d",
						got.found, "match_address", got.match_address, got.is_final);
					fail_count++;
				end else begin
					rep = match_reports.pop_front();
					if (got.found !== rep.found) begin
						$error("found: expected %0d, actual %0d", rep.found, got.found);
						fail_count++;
					end
					if (got.match_address !== rep.match_address) begin
						$error("match_address: expected %h, actual %h",
							rep.match_address, got.match_address);
						fail_count++;
					end
					if (got.is_final !== rep.is_final) begin
						$error("is_final: expected %0d, actual %0d", rep.is_final, got.is_final);
						fail_count++;
					end
				end
			end
			results_pending = match_reports.size();
		end
	end

endmodule

@@ bench/tb_wildcard_byte_pattern_scanner.sv @@
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner;
	import wbps_pkg::*;

	localparam int TOTAL_ITEMS   = 1400;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum {SINK_RANDOM, SINK_EAGER, SINK_HOLD} sink_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int         mismatches;
	int         pending;
	int         sent_count;
	int         cycle_count;
	bit         src_idle;
	bit         hold_served;
	sink_mode_t sink_phase;

	wbps_byte_if   byte_ch ();
	wbps_result_if result_ch ();

	wildcard_byte_pattern_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stream    (byte_ch),
		.result    (result_ch)
	);

	wbps_match_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.stream          (byte_ch),
		.result          (result_ch),
		.fail_count      (mismatches),
		.results_pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, eager stretches and one long hold-off
	initial begin
		result_ch.ready <= 1'b0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_phase == SINK_HOLD && !hold_served) begin
				hold_served = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (sink_phase != SINK_HOLD)
					hold_served = 1'b0;
				result_ch.ready <= (sink_phase == SINK_EAGER) ? 1'b1 : ($urandom_range(99) >= 20);
			end
		end
	end

	task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
		if (src_idle && $urandom_range(99) < 20) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.region_end <= last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_scanner(input logic [63:0] lo, input logic [63:0] hi,
		input logic [MASK_W-1:0] mask, input logic [LEN_W-1:0] len, input bit all,
		input logic [BASE_W-1:0] base);
		write_reg(REG_SIG_LOW, lo);
		write_reg(REG_SIG_HIGH, hi);
		write_reg(REG_WILD_MASK, CFG_DATA_W'(mask));
		write_reg(REG_SIG_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_FIND_ALL, CFG_DATA_W'(all));
		write_reg(REG_REGION_BASE, CFG_DATA_W'(base));
		cfg_write <= 1'b0;
	endtask

	// stop sending and let every outstanding result drain
	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [DATA_W-1:0] sig_pat [SIG_CAP];
		logic [DATA_W-1:0] plan [$];
		logic [63:0]       lo, hi;
		logic [MASK_W-1:0] mask;
		logic [LEN_W-1:0]  len;
		logic [BASE_W-1:0] base;
		bit                all;
		int                eff_len;
		int                pick;
		int                phase_no;
		sink_mode_t        next_phase;

		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_SIG_LOW;
		cfg_data <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.region_end <= 1'b0;
		sink_phase <= SINK_RANDOM;
		src_idle = 1'b1;
		sent_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: zero signature of length 4, first match only
		repeat (4) send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();

		// middle byte wildcard, find-all, start address wraps past the top
		load_scanner(64'h0000_0000_0000_00FF, 64'h0, 16'h0002, 5'd3, 1'b1, 32'hFFFF_FFFE);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();

		// overlapping candidates: only non-overlapping ones are reported
		load_scanner(64'h0000_0000_0000_AAAA, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 5'd2, 1'b1,
			32'h0000_1000);
		repeat (4) send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b1);
		settle();

		// zero length never matches
		load_scanner(64'h0000_0000_0000_AAAA, 64'h0, 16'hFFFF, 5'd0, 1'b1, 32'h0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hAA, 1'b1);
		settle();

		phase_no = 0;
		while (sent_count < TOTAL_ITEMS) begin
			foreach (sig_pat[k])
				sig_pat[k] = DATA_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 4)
				len = 5'd0;
			else if (pick < 10)
				len = LEN_W'($urandom_range(31, 17));
			else if (pick < 70)
				len = LEN_W'($urandom_range(4, 1));
			else
				len = LEN_W'($urandom_range(16, 5));
			mask = MASK_W'($urandom & $urandom);
			all = 1'($urandom_range(1));
			base = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(63) : $urandom;
			pick = $urandom_range(60, 10);
			src_idle = 1'b1;
			next_phase = SINK_RANDOM;
			if (phase_no == 2) begin
				src_idle = 1'b0;
				next_phase = SINK_EAGER;
				pick = 250;
			end else if (phase_no == 5) begin
				// every byte matches, so the held-off result side backs up the input
				len = 5'd1;
				mask = '1;
				all = 1'b1;
				src_idle = 1'b0;
				next_phase = SINK_HOLD;
				pick = 40;
			end
			sink_phase <= next_phase;
			for (int k = 0; k < SIG_CAP; k++) begin
				if (k < 8)
					lo[8*k +: 8] = sig_pat[k];
				else
					hi[8*(k-8) +: 8] = sig_pat[k];
			end
			load_scanner(lo, hi, mask, len, all, base);
			eff_len = (len > SIG_CAP) ? SIG_CAP : int'(len);
			plan.delete();
			repeat (pick) begin
				if (plan.size() == 0) begin
					if (eff_len > 0 && $urandom_range(99) < 55) begin
						for (int k = 0; k < eff_len; k++)
							plan = {plan, (mask[k] ? DATA_W'($urandom) : sig_pat[k])};
						if ($urandom_range(9) == 0)
							plan[$urandom_range(eff_len - 1)] ^= DATA_W'(1 << $urandom_range(7));
					end else begin
						repeat ($urandom_range(3, 1))
							plan = {plan, ($urandom_range(1) ? DATA_W'($urandom) :
								sig_pat[$urandom_range(SIG_CAP - 1)])};
					end
				end
				send_byte(plan.pop_front(), $urandom_range(99) < 4);
			end
			settle();
			phase_no++;
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
